// File: hw/rtl/pvnd_pkg.sv
// Package with the shared types and constants of the prefixed number decoder.
`timescale 1ns / 1ps
`default_nettype none

package pvnd_pkg;

    // Longest number, in bytes, that is reported as good.
    localparam int unsigned VALUE_BYTES = 4;
    localparam logic [8:0]  VALUE_BYTES_W = 9'(VALUE_BYTES);

    // Special byte codes of the stream.
    localparam logic [7:0] BYTE_PREFIX = 8'hFF;
    localparam logic [7:0] BYTE_ESCAPE = 8'h00;

    localparam int unsigned VALUE_W = 32;
    localparam int unsigned OUT_TDATA_W = 40;

    // Result status codes.
    typedef enum logic [1:0] {
        STATUS_OK    = 2'd0,
        STATUS_TRUNC = 2'd1,
        STATUS_LONG  = 2'd2
    } status_t;

    // Decoder phase.
    typedef enum logic {
        PHASE_IDLE = 1'b0,
        PHASE_BODY = 1'b1
    } phase_t;

    // One result as passed from the decode core to the output stage.
    typedef struct packed {
        logic               valid;
        logic [VALUE_W-1:0] value;
        status_t            status;
    } result_t;

endpackage : pvnd_pkg

`default_nettype wire

// File: hw/rtl/pvnd_core.sv
// Decode core: prefix counting, body accumulation and result generation.
`timescale 1ns / 1ps
`default_nettype none

module pvnd_core (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              in_take,
    input  wire logic [7:0]        in_byte,
    input  wire logic              in_eos,
    output pvnd_pkg::result_t      res
);
    import pvnd_pkg::*;

    phase_t             phase_reg, phase_next;
    logic [7:0]         prefix_reg, prefix_next;
    logic [7:0]         left_reg, left_next;
    logic [VALUE_W-1:0] acc_reg, acc_next;
    logic               long_reg, long_next;

    logic [VALUE_W-1:0] body_acc;
    logic [7:0]         body_left;
    logic               start_escape;
    logic [8:0]         start_total;
    logic [VALUE_W-1:0] start_acc;
    logic [7:0]         start_left;
    logic               start_long;

    // Values for a body byte and for the first byte of a number.
    always_comb begin
        body_acc     = {acc_reg[VALUE_W-9:0], in_byte};
        body_left    = (left_reg != 8'd0) ? (left_reg - 8'd1) : 8'd0;
        start_escape = (prefix_reg != 8'd0) && (in_byte == BYTE_ESCAPE);
        if (start_escape) begin
            start_total = {1'b0, prefix_reg};
            start_acc   = VALUE_W'(BYTE_PREFIX);
            start_left  = prefix_reg - 8'd1;
        end else begin
            start_total = {1'b0, prefix_reg} + 9'd1;
            start_acc   = VALUE_W'(in_byte);
            start_left  = prefix_reg;
        end
        start_long = start_total > VALUE_BYTES_W;
    end

    // Next state.
    always_comb begin
        phase_next  = phase_reg;
        prefix_next = prefix_reg;
        left_next   = left_reg;
        acc_next    = acc_reg;
        long_next   = long_reg;
        if (in_take) begin
            if (in_eos) begin
                phase_next  = PHASE_IDLE;
                prefix_next = 8'd0;
                left_next   = 8'd0;
                acc_next    = '0;
                long_next   = 1'b0;
            end else begin
                case (phase_reg)
                    PHASE_BODY: begin
                        if (body_left == 8'd0) begin
                            phase_next  = PHASE_IDLE;
                            prefix_next = 8'd0;
                            left_next   = 8'd0;
                            acc_next    = '0;
                            long_next   = 1'b0;
                        end else begin
                            left_next = body_left;
                            acc_next  = body_acc;
                        end
                    end
                    PHASE_IDLE: begin
                        if (in_byte == BYTE_PREFIX) begin
                            if (prefix_reg != 8'hFF) begin
                                prefix_next = prefix_reg + 8'd1;
                            end
                        end else if (start_left == 8'd0) begin
                            prefix_next = 8'd0;
                            left_next   = 8'd0;
                            acc_next    = '0;
                            long_next   = 1'b0;
                        end else begin
                            phase_next = PHASE_BODY;
                            left_next  = start_left;
                            acc_next   = start_acc;
                            long_next  = start_long;
                        end
                    end
                    default: begin
                        phase_next = PHASE_IDLE;
                    end
                endcase
            end
        end
    end

    // Result of the byte in hand.
    always_comb begin
        res.valid  = 1'b0;
        res.value  = '0;
        res.status = STATUS_OK;
        if (in_take) begin
            if (in_eos) begin
                if ((phase_reg == PHASE_BODY) || (prefix_reg != 8'd0)) begin
                    res.valid  = 1'b1;
                    res.status = STATUS_TRUNC;
                end
            end else begin
                case (phase_reg)
                    PHASE_BODY: begin
                        if (body_left == 8'd0) begin
                            res.valid = 1'b1;
                            if (long_reg) begin
                                res.status = STATUS_LONG;
                            end else begin
                                res.value = body_acc;
                            end
                        end
                    end
                    PHASE_IDLE: begin
                        if ((in_byte != BYTE_PREFIX) && (start_left == 8'd0)) begin
                            res.valid = 1'b1;
                            if (start_long) begin
                                res.status = STATUS_LONG;
                            end else begin
                                res.value = start_acc;
                            end
                        end
                    end
                    default: begin
                        res.valid = 1'b0;
                    end
                endcase
            end
        end
    end

    // State registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PHASE_IDLE;
            prefix_reg <= 8'd0;
            left_reg   <= 8'd0;
            acc_reg    <= '0;
            long_reg   <= 1'b0;
        end else begin
            phase_reg  <= phase_next;
            prefix_reg <= prefix_next;
            left_reg   <= left_next;
            acc_reg    <= acc_next;
            long_reg   <= long_next;
        end
    end

endmodule : pvnd_core

`default_nettype wire

// File: hw/rtl/prefixed_varlen_number_decoder.sv
// Top level of the prefixed variable-length number decoder with its output stage.
//
//  Channel  Direction  tdata bits (lowest first)                  tuser/tlast
//  s_       in         [7:0] data_byte                            tlast = end_of_stream
//  m_       out        [31:0] value, [33:32] status, [39:34] zero  none
//
// One byte request is taken in every cycle while s_tready is high; the decode
// state is one step of compare, count and shift, so a result is registered in
// the output or skid register as the byte that finishes a number is taken. A
// two-entry output stage (output and skid register) lets input continue while a
// result waits; s_tready falls only when both entries are full. Reset (aresetn
// low at a clock edge) returns the decoder to idle and empties the output stage.
`timescale 1ns / 1ps
`default_nettype none

module prefixed_varlen_number_decoder (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output      logic        s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] data_byte
    input  wire logic        s_tlast,   // end_of_stream
    output      logic        m_tvalid,
    input  wire logic        m_tready,
    output      logic [39:0] m_tdata    // [31:0] value, [33:32] status, rest zero
);
    import pvnd_pkg::*;

    logic    in_take;
    result_t res;

    logic               out_valid_reg, out_valid_next;
    logic [VALUE_W-1:0] out_value_reg, out_value_next;
    status_t            out_status_reg, out_status_next;
    logic               skid_valid_reg, skid_valid_next;
    logic [VALUE_W-1:0] skid_value_reg, skid_value_next;
    status_t            skid_status_reg, skid_status_next;

    assign s_tready = !skid_valid_reg;
    assign in_take  = s_tvalid && s_tready;

    pvnd_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .in_take (in_take),
        .in_byte (s_tdata),
        .in_eos  (s_tlast),
        .res     (res)
    );

    // Output register and skid register.
    always_comb begin
        out_valid_next   = out_valid_reg;
        out_value_next   = out_value_reg;
        out_status_next  = out_status_reg;
        skid_valid_next  = skid_valid_reg;
        skid_value_next  = skid_value_reg;
        skid_status_next = skid_status_reg;
        if (!out_valid_reg || m_tready) begin
            if (skid_valid_reg) begin
                out_valid_next  = 1'b1;
                out_value_next  = skid_value_reg;
                out_status_next = skid_status_reg;
                skid_valid_next = 1'b0;
            end else begin
                out_valid_next  = res.valid;
                out_value_next  = res.value;
                out_status_next = res.status;
            end
        end else if (res.valid) begin
            skid_valid_next  = 1'b1;
            skid_value_next  = res.value;
            skid_status_next = res.status;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
        out_value_reg   <= out_value_next;
        out_status_reg  <= out_status_next;
        skid_value_reg  <= skid_value_next;
        skid_status_reg <= skid_status_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {(OUT_TDATA_W - VALUE_W - 2)'(0), out_status_reg, out_value_reg};

    // The skid entry is only ever filled behind a waiting output entry.
    a_skid_behind_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry holds a result while the output entry is empty");

    // A failed number always carries a zero value.
    a_zero_on_error: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tdata[33:32] != STATUS_OK)) |-> (m_tdata[31:0] == 32'd0))
        else $error("nonzero value with an error status");

    // The padding bits and the unused status code never appear.
    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ((m_tdata[33:32] != 2'd3) && (m_tdata[39:34] == 6'd0)))
        else $error("bad status code or padding on the result channel");

    // A result that meets a full stage is held in the skid entry next cycle.
    a_no_drop: assert property (@(posedge aclk) disable iff (!aresetn)
        (res.valid && out_valid_reg && !m_tready) |=> skid_valid_reg)
        else $error("result dropped while the output entry was stalled");

endmodule : prefixed_varlen_number_decoder

`default_nettype wire

// File: test/testbench.sv
// Self-checking testbench for the prefixed variable-length number decoder.
`timescale 1ns / 1ps
`default_nettype none

module testbench;
    import pvnd_pkg::*;

    // One queued stream request, or a marker that holds the sender until all numbers are out.
    typedef struct {
        bit         pause;
        logic [7:0] data;
        logic       last;
    } stream_req_t;

    // One decoded number as the decoder should return it.
    typedef struct {
        logic [31:0] value;
        status_t     status;
    } number_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'd0;    // [7:0] data_byte
    logic        s_tlast = 1'b0;    // end_of_stream
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;           // [31:0] value, [33:32] status, [39:34] zero

    stream_req_t stream_q[$];
    number_t     pending_numbers[$];

    // Shadow of the decoder state.
    phase_t      dec_phase = PHASE_IDLE;
    logic [7:0]  dec_prefix = 8'd0;
    logic [7:0]  dec_left = 8'd0;
    logic [31:0] dec_acc = 32'd0;
    logic        dec_long = 1'b0;

    int errors = 0;
    int bytes_queued = 0;
    int bytes_sent = 0;
    int count_ok = 0;
    int count_trunc = 0;
    int count_long = 0;

    bit took_in = 1'b0;
    bit took_out = 1'b0;
    bit draining = 1'b0;
    bit send_fast = 1'b0;
    bit recv_fast = 1'b0;
    int send_idle = 0;
    int recv_idle = 0;
    int results_seen = 0;

    prefixed_varlen_number_decoder u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // Clock with a 4 ns period.
    always #2 aclk = ~aclk;

    // Mismatch reporting.
    task automatic report_mismatch(input string msg);
        $display("tb: mismatch at %0t: %s", $realtime, msg);
        errors++;
    endtask

    // Return the shadow decoder to idle.
    task automatic clear_decoder();
        dec_phase  = PHASE_IDLE;
        dec_prefix = 8'd0;
        dec_left   = 8'd0;
        dec_acc    = 32'd0;
        dec_long   = 1'b0;
    endtask

    // Record an expected number and go back to idle.
    task automatic emit_number(input logic [31:0] value, input status_t status);
        number_t n;
        n.value  = value;
        n.status = status;
        pending_numbers.push_back(n);
        clear_decoder();
    endtask

    // Emit the number once its last body byte has arrived.
    task automatic close_if_complete();
        if (dec_left == 8'd0) begin
            if (dec_long) begin
                emit_number(32'd0, STATUS_LONG);
            end else begin
                emit_number(dec_acc, STATUS_OK);
            end
        end
    endtask

    // Advance the shadow decoder by one accepted stream byte.
    task automatic decode_byte(input logic [7:0] b, input logic eos);
        logic [8:0] total;
        if (eos) begin
            if (dec_phase == PHASE_BODY || dec_prefix != 8'd0) begin
                emit_number(32'd0, STATUS_TRUNC);
            end else begin
                clear_decoder();
            end
        end else if (dec_phase == PHASE_BODY) begin
            dec_acc = {dec_acc[23:0], b};
            if (dec_left != 8'd0) begin
                dec_left--;
            end
            close_if_complete();
        end else if (b == BYTE_PREFIX) begin
            if (dec_prefix != 8'hFF) begin
                dec_prefix++;
            end
        end else begin
            // An escape byte after a prefix stands for a leading 0xFF.
            if (dec_prefix != 8'd0 && b == BYTE_ESCAPE) begin
                total    = {1'b0, dec_prefix};
                dec_acc  = 32'h0000_00FF;
                dec_left = dec_prefix - 8'd1;
            end else begin
                total    = {1'b0, dec_prefix} + 9'd1;
                dec_acc  = {24'd0, b};
                dec_left = dec_prefix;
            end
            dec_long  = total > VALUE_BYTES_W;
            dec_phase = PHASE_BODY;
            close_if_complete();
        end
    endtask

    // Compare one returned number with the oldest expectation.
    task automatic check_number(input logic [39:0] word);
        number_t want;
        if (pending_numbers.size() == 0) begin
            report_mismatch($sformatf("unexpected result %h", word));
        end else begin
            want = pending_numbers.pop_front();
            if (word[31:0] !== want.value) begin
                report_mismatch($sformatf("value %h, expected %h", word[31:0], want.value));
            end
            if (word[33:32] !== want.status) begin
                report_mismatch($sformatf("status %0d, expected %0d", word[33:32], want.status));
            end
            if (word[39:34] !== 6'd0) begin
                report_mismatch($sformatf("padding bits %b not zero", word[39:34]));
            end
            case (want.status)
                STATUS_OK: begin
                    count_ok++;
                end
                STATUS_TRUNC: begin
                    count_trunc++;
                end
                default: begin
                    count_long++;
                end
            endcase
        end
    endtask

    // Stimulus builders.
    task automatic push_byte(input logic [7:0] b);
        stream_req_t r;
        r.pause = 1'b0;
        r.data  = b;
        r.last  = 1'b0;
        stream_q.push_back(r);
        bytes_queued++;
    endtask

    task automatic push_end();
        stream_req_t r;
        r.pause = 1'b0;
        r.data  = 8'($urandom_range(0, 255));
        r.last  = 1'b1;
        stream_q.push_back(r);
        bytes_queued++;
    endtask

    task automatic push_pause();
        stream_req_t r;
        r.pause = 1'b1;
        r.data  = 8'd0;
        r.last  = 1'b0;
        stream_q.push_back(r);
    endtask

    // A number with random content; when cut_short is set it is closed early by end of stream.
    task automatic push_number(input int n_prefix, input bit cut_short);
        logic [7:0] seq[$];
        int         body;
        int         keep;
        repeat (n_prefix) seq.push_back(BYTE_PREFIX);
        if (n_prefix != 0 && $urandom_range(0, 3) == 0) begin
            seq.push_back(BYTE_ESCAPE);
            body = n_prefix - 1;
        end else begin
            seq.push_back(8'($urandom_range(0, 254)));
            body = n_prefix;
        end
        repeat (body) seq.push_back(8'($urandom_range(0, 255)));
        keep = cut_short ? $urandom_range(0, seq.size() - 1) : seq.size();
        for (int i = 0; i < keep; i++) begin
            push_byte(seq[i]);
        end
        if (cut_short) begin
            push_end();
        end
    endtask

    // Sender: presents queued requests at the falling edge with random gaps.
    always @(negedge aclk) begin
        stream_req_t r;
        logic        nv;
        nv = s_tvalid;
        if (aresetn) begin
            if (s_tvalid && took_in) begin
                nv = 1'b0;
            end
            if (!nv) begin
                if (send_idle > 0) begin
                    send_idle--;
                end else if (draining) begin
                    if (pending_numbers.size() == 0) begin
                        draining = 1'b0;
                    end
                end else if (stream_q.size() != 0) begin
                    r = stream_q.pop_front();
                    if (r.pause) begin
                        draining = 1'b1;
                    end else begin
                        s_tdata <= r.data;
                        s_tlast <= r.last;
                        nv = 1'b1;
                        bytes_sent++;
                        if (bytes_sent % 40 == 0) begin
                            send_fast = ($urandom_range(0, 3) == 0);
                        end
                        send_idle = send_fast ? 0 : $urandom_range(0, 12);
                    end
                end
            end
        end
        s_tvalid <= nv;
    end

    // Receiver: stalls a random number of cycles after each taken result.
    always @(negedge aclk) begin
        logic nr;
        nr = m_tready;
        if (aresetn) begin
            if (took_out) begin
                results_seen++;
                if (results_seen % 20 == 0) begin
                    recv_fast = ($urandom_range(0, 2) == 0);
                end
                recv_idle = recv_fast ? 0 : $urandom_range(0, 12);
            end
            if (recv_idle > 0) begin
                recv_idle--;
                nr = 1'b0;
            end else begin
                nr = 1'b1;
            end
        end
        m_tready <= nr;
    end

    // Monitor: samples both channels at the rising edge.
    always @(posedge aclk) begin
        if (!aresetn) begin
            took_in  <= 1'b0;
            took_out <= 1'b0;
            clear_decoder();
        end else begin
            took_in  <= s_tvalid && s_tready;
            took_out <= m_tvalid && m_tready;
            if (s_tvalid && s_tready) begin
                decode_byte(s_tdata, s_tlast);
            end
            if (m_tvalid && m_tready) begin
                check_number(m_tdata);
            end
        end
    end

    // Stimulus, reset and end of run.
    initial begin
        int pick;
        int n_prefix;

        // Directed: lone zero, escaped single 0xFF, largest value through an escape.
        push_byte(8'h00);
        push_byte(8'hFF);
        push_byte(8'h00);
        repeat (4) push_byte(8'hFF);
        push_byte(8'h00);
        repeat (3) push_byte(8'hFF);
        // End at idle, end after a prefix, end inside a body.
        push_end();
        push_byte(8'hFF);
        push_end();
        push_byte(8'hFF);
        push_byte(8'h01);
        push_end();
        // Five bytes: one more than the decoder keeps.
        repeat (4) push_byte(8'hFF);
        push_byte(8'h01);
        push_byte(8'h02);
        push_byte(8'h03);
        push_byte(8'h04);
        push_byte(8'h05);
        push_pause();

        // Prefix run beyond the saturation point, followed by its full body.
        repeat (260) push_byte(8'hFF);
        push_byte(8'h05);
        repeat (255) push_byte(8'($urandom_range(0, 255)));
        push_pause();

        // Random mix: mostly well-formed numbers, some cut short, some noise.
        while (bytes_queued < 750) begin
            pick = $urandom_range(0, 99);
            n_prefix = ($urandom_range(0, 4) == 0) ? $urandom_range(4, 8) : $urandom_range(0, 3);
            if (pick < 70) begin
                push_number(n_prefix, 1'b0);
            end else if (pick < 80) begin
                push_number(n_prefix, 1'b1);
            end else if (pick < 87) begin
                push_end();
            end else if (pick < 98) begin
                repeat ($urandom_range(1, 4)) push_byte(8'($urandom_range(0, 255)));
            end else begin
                push_pause();
            end
        end
        push_end();

        // Hold reset, then release it at a falling edge.
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        while (stream_q.size() != 0 || s_tvalid || draining || pending_numbers.size() != 0) begin
            @(negedge aclk);
        end
        repeat (16) @(posedge aclk);

        $display("tb: %0d stream bytes sent, including a saturated prefix run and end markers",
                 bytes_sent);
        $display("tb: numbers checked: %0d good, %0d truncated, %0d too long",
                 count_ok, count_trunc, count_long);
        if (errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    // Watchdog.
    initial begin
        #(2_000_000);
        $display("tb: failure");
        $finish;
    end

endmodule

`default_nettype wire
